>>> hw/rtl/lff_pkg.sv
// ----------------------------------------------------------------------------
// lff_pkg
// Shared constants, codes and types of the fluctuating force unit.
// ----------------------------------------------------------------------------
package lff_pkg;

   localparam int NUM_STEPS       = 64;
   localparam int NUM_OBSERVABLES = 4;

   localparam int TSTEPS = (NUM_STEPS < 64) ? NUM_STEPS : 64;
   localparam int NOBS   = (NUM_OBSERVABLES < 8) ? NUM_OBSERVABLES : 8;

   localparam int TIME_W = 6;
   localparam int OBS_W  = 3;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 4;
   localparam int JOB_W  = 4;
   localparam int WGT_W  = 4;
   localparam int ACC_W  = 64;

   localparam int HIST_DEPTH  = TSTEPS * NOBS;
   localparam int DRIFT_DEPTH = TSTEPS * NOBS * NOBS;
   localparam int KERN_DEPTH  = TSTEPS * TSTEPS * NOBS * NOBS;
   localparam int HIST_AW     = $clog2(HIST_DEPTH);
   localparam int DRIFT_AW    = $clog2(DRIFT_DEPTH);
   localparam int KERN_AW     = $clog2(KERN_DEPTH);

   localparam logic [ACC_W-1:0] CLAMP_MAG = 64'h1000_0000_0000_0000;

   localparam logic [1:0] MODE_KERNEL = 2'd0;
   localparam logic [1:0] MODE_DRIFT  = 2'd1;
   localparam logic [1:0] MODE_SAMPLE = 2'd2;

   localparam int          CSR_IDX_W        = 1;
   localparam logic [0:0]  CSR_INVERSE_STEP = 1'd0;
   localparam logic [0:0]  CSR_STEP_THIRD   = 1'd1;
   localparam logic [31:0] INVERSE_STEP_RST = 32'd65536;
   localparam logic [31:0] STEP_THIRD_RST   = 32'd21845;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_LAUNCH,
      CTL_WAIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_GEN,
      ENG_DRAIN,
      ENG_DSTART,
      ENG_DWAIT,
      ENG_KSTART,
      ENG_KWAIT,
      ENG_DONE
   } eng_state_type;

   typedef enum logic [1:0] {
      GEN_DPOS,
      GEN_DNEG,
      GEN_DRIFT,
      GEN_KERN
   } gen_phase_type;

   typedef enum logic [2:0] {
      SCL_IDLE,
      SCL_HI,
      SCL_LO,
      SCL_OUT,
      SCL_DONE
   } scl_state_type;

   typedef struct packed {
      logic              valid;
      gen_phase_type     kind;
      logic [WGT_W-1:0]  weight;
   } tag_type;

   typedef struct packed {
      logic [TIME_W-1:0] u;
      logic              at_end;
      logic [OBS_W-1:0]  obs;
   } job_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] force_val;
   } eng_res_type;

endpackage

>>> hw/rtl/lff_ram.sv
// ----------------------------------------------------------------------------
// lff_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lff_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lff_scale.sv
// ----------------------------------------------------------------------------
// lff_scale
// Rounded, clamped product of a 64 bit value and a Q16.16 coefficient,
// shifted by 16 or 17; one 32x32 multiplier used twice.
// ----------------------------------------------------------------------------
module lff_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [63:0]      value,
   input  logic [31:0]             coef,
   input  logic                    half,
   output logic                    done,
   output logic signed [63:0]      result
);
   import lff_pkg::*;

   scl_state_type     state_ff, state_in;
   logic [63:0]       mag_ff;
   logic              neg_ff;
   logic              half_ff;
   logic [31:0]       coef_ff;
   logic [63:0]       phi_ff;
   logic [63:0]       plo_ff;
   logic signed [63:0] result_ff;

   logic [31:0]       mul_a;
   logic [63:0]       prod;
   logic [63:0]       thr;
   logic [63:0]       r_sum;
   logic [63:0]       r_fin;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCL_IDLE: if (start) state_in = SCL_HI;
         SCL_HI:   state_in = SCL_LO;
         SCL_LO:   state_in = SCL_OUT;
         SCL_OUT:  state_in = SCL_DONE;
         SCL_DONE: state_in = SCL_IDLE;
         default:  state_in = SCL_IDLE;
      endcase
   end

   assign mul_a = (state_ff == SCL_HI) ? mag_ff[63:32] : mag_ff[31:0];
   assign prod  = 64'(mul_a) * 64'(coef_ff);
   assign thr   = half_ff ? (64'd1 << 45) : (64'd1 << 44);

   always_comb begin
      if (half_ff) begin
         r_sum = (phi_ff << 15) + (plo_ff >> 17) + 64'(plo_ff[16]);
      end else begin
         r_sum = (phi_ff << 16) + (plo_ff >> 16) + 64'(plo_ff[15]);
      end
      if (phi_ff >= thr || r_sum > CLAMP_MAG) begin
         r_fin = CLAMP_MAG;
      end else begin
         r_fin = r_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SCL_IDLE && start) begin
         mag_ff  <= value[63] ? (64'd0 - value) : value;
         neg_ff  <= value[63];
         half_ff <= half;
         coef_ff <= coef;
      end
      if (state_ff == SCL_HI) begin
         phi_ff <= prod;
      end
      if (state_ff == SCL_LO) begin
         plo_ff <= prod;
      end
      if (state_ff == SCL_OUT) begin
         result_ff <= neg_ff ? -$signed(r_fin) : $signed(r_fin);
      end
   end

   assign done   = (state_ff == SCL_DONE);
   assign result = result_ff;

endmodule

>>> hw/rtl/lff_engine.sv
// ----------------------------------------------------------------------------
// lff_engine
// Computes one force value: streams history, drift and kernel reads through
// a multiply and accumulate pipeline, then scales and combines.
// ----------------------------------------------------------------------------
module lff_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  lff_pkg::job_type                  job,
   input  logic [31:0]                       inverse_step,
   input  logic [31:0]                       step_third,
   input  logic                              take,
   output lff_pkg::eng_res_type              res,
   output logic                              busy,
   output logic [lff_pkg::HIST_AW-1:0]       hist_raddr,
   output logic [lff_pkg::DRIFT_AW-1:0]      drift_raddr,
   output logic [lff_pkg::KERN_AW-1:0]       kern_raddr,
   input  logic [lff_pkg::DATA_W-1:0]        hist_rdata,
   input  logic [lff_pkg::DATA_W-1:0]        drift_rdata,
   input  logic [lff_pkg::DATA_W-1:0]        kern_rdata
);
   import lff_pkg::*;

   eng_state_type      state_ff, state_in;
   gen_phase_type      gph_ff, gph_in;
   logic [OBS_W-1:0]   k_ff, k_in;
   logic [TIME_W-1:0]  t2_ff, t2_in;
   job_type            job_ff;

   tag_type            tag_in;
   tag_type            s1_ff, s2_ff, s3_ff;
   logic signed [ACC_W-1:0] p2_ff, q3_ff;
   logic signed [ACC_W-1:0] diff_ff, drift_ff, kacc_ff, dres_ff;
   logic signed [DATA_W-1:0] force_ff;

   logic [TIME_W-1:0]  rd_time;
   logic [OBS_W-1:0]   rd_obs;
   logic [TIME_W-1:0]  tpos, tneg, e_end;
   logic               has_deriv, start_deriv, sh17;
   logic [WGT_W-1:0]   wgt;
   logic [OBS_W-1:0]   k_last;

   logic signed [DATA_W-1:0] coef_s1;
   logic signed [ACC_W-1:0]  prod_s1;
   logic signed [ACC_W-1:0]  rnd_s2;
   logic signed [ACC_W-1:0]  q_s2;

   logic               sc_start, sc_half, sc_done;
   logic signed [ACC_W-1:0] sc_value, sc_result;
   logic [31:0]        sc_coef;
   logic signed [ACC_W-1:0] total;
   logic signed [DATA_W-1:0] total_sat;

   assign k_last      = OBS_W'(NOBS - 1);
   assign has_deriv   = !(job_ff.u == '0 && job_ff.at_end);
   assign start_deriv = !(job.u == '0 && job.at_end);
   assign sh17        = (job_ff.u != '0) && !job_ff.at_end;

   always_comb begin
      if (job_ff.u == '0) begin
         tpos = TIME_W'(1);
         tneg = '0;
      end else if (job_ff.at_end) begin
         tpos = job_ff.u;
         tneg = job_ff.u - TIME_W'(1);
      end else begin
         tpos = job_ff.u + TIME_W'(1);
         tneg = job_ff.u - TIME_W'(1);
      end
   end

   // doubled Simpson weights, trapezoid tail on odd u
   always_comb begin
      e_end = job_ff.u[0] ? (job_ff.u - TIME_W'(1)) : job_ff.u;
      wgt   = '0;
      if (job_ff.u[0] && t2_ff == job_ff.u) begin
         wgt = WGT_W'(3);
      end else begin
         if (e_end != '0) begin
            if (t2_ff == '0 || t2_ff == e_end) wgt = WGT_W'(2);
            else if (t2_ff[0])                 wgt = WGT_W'(8);
            else                               wgt = WGT_W'(4);
         end
         if (job_ff.u[0] && t2_ff == e_end) wgt = wgt + WGT_W'(3);
      end
   end

   always_comb begin
      state_in = state_ff;
      gph_in   = gph_ff;
      k_in     = k_ff;
      t2_in    = t2_ff;
      tag_in   = '{valid: 1'b0, kind: GEN_DRIFT, weight: '0};
      rd_time  = job_ff.u;
      rd_obs   = k_ff;
      sc_start = 1'b0;
      sc_value = diff_ff;
      sc_coef  = inverse_step;
      sc_half  = sh17;
      unique case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               state_in = ENG_GEN;
               gph_in   = start_deriv ? GEN_DPOS : GEN_DRIFT;
               k_in     = '0;
               t2_in    = '0;
            end
         end
         ENG_GEN: begin
            tag_in.valid = 1'b1;
            tag_in.kind  = gph_ff;
            tag_in.weight = wgt;
            unique case (gph_ff)
               GEN_DPOS: begin
                  rd_time = tpos;
                  rd_obs  = job_ff.obs;
                  gph_in  = GEN_DNEG;
               end
               GEN_DNEG: begin
                  rd_time = tneg;
                  rd_obs  = job_ff.obs;
                  gph_in  = GEN_DRIFT;
               end
               GEN_DRIFT: begin
                  rd_time = job_ff.u;
                  if (k_ff == k_last) begin
                     k_in = '0;
                     if (job_ff.u == '0) state_in = ENG_DRAIN;
                     else gph_in = GEN_KERN;
                  end else begin
                     k_in = k_ff + OBS_W'(1);
                  end
               end
               GEN_KERN: begin
                  rd_time = t2_ff;
                  if (k_ff == k_last) begin
                     k_in = '0;
                     if (t2_ff == job_ff.u) state_in = ENG_DRAIN;
                     else t2_in = t2_ff + TIME_W'(1);
                  end else begin
                     k_in = k_ff + OBS_W'(1);
                  end
               end
               default: gph_in = GEN_DRIFT;
            endcase
         end
         ENG_DRAIN: begin
            if (!s1_ff.valid && !s2_ff.valid && !s3_ff.valid) state_in = ENG_DSTART;
         end
         ENG_DSTART: begin
            sc_start = 1'b1;
            state_in = ENG_DWAIT;
         end
         ENG_DWAIT: begin
            if (sc_done) state_in = ENG_KSTART;
         end
         ENG_KSTART: begin
            sc_start = 1'b1;
            sc_value = kacc_ff;
            sc_coef  = step_third;
            sc_half  = 1'b1;
            state_in = ENG_KWAIT;
         end
         ENG_KWAIT: begin
            sc_value = kacc_ff;
            sc_coef  = step_third;
            sc_half  = 1'b1;
            if (sc_done) state_in = ENG_DONE;
         end
         ENG_DONE: begin
            if (take) state_in = ENG_IDLE;
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   assign hist_raddr  = HIST_AW'(int'(rd_time) * NOBS + int'(rd_obs));
   assign drift_raddr = DRIFT_AW'((int'(job_ff.u) * NOBS + int'(job_ff.obs)) * NOBS
                                  + int'(k_ff));
   assign kern_raddr  = KERN_AW'(((int'(job_ff.u) * TSTEPS + int'(t2_ff)) * NOBS
                                  + int'(job_ff.obs)) * NOBS + int'(k_ff));

   assign coef_s1 = (s1_ff.kind == GEN_DRIFT) ? $signed(drift_rdata) : $signed(kern_rdata);
   always_comb begin
      if (s1_ff.kind == GEN_DPOS || s1_ff.kind == GEN_DNEG) begin
         prod_s1 = ACC_W'($signed(hist_rdata));
      end else begin
         prod_s1 = $signed(hist_rdata) * coef_s1;
      end
   end

   // round to nearest, ties away from zero
   assign rnd_s2 = p2_ff + (p2_ff[ACC_W-1] ? 64'sd32767 : 64'sd32768);
   assign q_s2   = (s2_ff.kind == GEN_DPOS || s2_ff.kind == GEN_DNEG) ? p2_ff
                                                                     : (rnd_s2 >>> 16);

   always_comb begin
      total = diff_ff;
      total = dres_ff - drift_ff - sc_result;
      if (total > 64'sd2147483647)       total_sat = 32'sh7fff_ffff;
      else if (total < -64'sd2147483648) total_sat = 32'sh8000_0000;
      else                               total_sat = total[DATA_W-1:0];
   end

   lff_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .value  (sc_value),
      .coef   (sc_coef),
      .half   (sc_half),
      .done   (sc_done),
      .result (sc_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         s1_ff    <= '0;
         s2_ff    <= '0;
         s3_ff    <= '0;
      end else begin
         state_ff <= state_in;
         s1_ff    <= tag_in;
         s2_ff    <= s1_ff;
         s3_ff    <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      gph_ff <= gph_in;
      k_ff   <= k_in;
      t2_ff  <= t2_in;
      p2_ff  <= prod_s1;
      q3_ff  <= q_s2;
      if (state_ff == ENG_IDLE && start) begin
         job_ff   <= job;
         diff_ff  <= '0;
         drift_ff <= '0;
         kacc_ff  <= '0;
      end else if (s3_ff.valid) begin
         unique case (s3_ff.kind)
            GEN_DPOS:  diff_ff  <= diff_ff + q3_ff;
            GEN_DNEG:  diff_ff  <= diff_ff - q3_ff;
            GEN_DRIFT: drift_ff <= drift_ff + q3_ff;
            GEN_KERN:  kacc_ff  <= kacc_ff + q3_ff * $signed({1'b0, s3_ff.weight});
            default:   drift_ff <= drift_ff;
         endcase
      end
      if (state_ff == ENG_DWAIT && sc_done) begin
         dres_ff <= has_deriv ? sc_result : '0;
      end
      if (state_ff == ENG_KWAIT && sc_done) begin
         force_ff <= total_sat;
      end
   end

   assign res.valid     = (state_ff == ENG_DONE);
   assign res.force_val = force_ff;
   assign busy          = (state_ff != ENG_IDLE);

endmodule

>>> hw/rtl/langevin_fluctuating_force_unit.sv
// ----------------------------------------------------------------------------
// langevin_fluctuating_force_unit
// Loads kernel and drift entries, takes trajectory samples in time order and
// emits the fluctuating force of each completed step.
// A load or a sample that does not complete a step does not stall the input.
// A completing sample yields up to 2*NOBS forces; for each, the engine makes
// one history/kernel read per cycle while it generates the terms.
// Input stalls until the last force of the step has entered the output word.
// Reset clears counters and control; store contents are undefined until written.
// ----------------------------------------------------------------------------
module langevin_fluctuating_force_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [lff_pkg::TIME_W-1:0]          req_time_a,
   input  logic [lff_pkg::TIME_W-1:0]          req_time_b,
   input  logic [lff_pkg::OBS_W-1:0]           req_row_obs,
   input  logic [lff_pkg::OBS_W-1:0]           req_col_obs,
   input  logic signed [lff_pkg::DATA_W-1:0]   req_value,
   input  logic                                req_final_step,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lff_pkg::TIME_W-1:0]          rsp_out_time,
   output logic [lff_pkg::OBS_W-1:0]           rsp_out_obs,
   output logic signed [lff_pkg::DATA_W-1:0]   rsp_force_res,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [lff_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_data
);
   import lff_pkg::*;

   ctl_state_type      ctl_state_ff, ctl_state_in;
   logic [31:0]        inv_step_ff, step_third_ff;
   logic [TIME_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   obs_cnt_ff, obs_cnt_in;
   logic [JOB_W-1:0]   job_idx_ff, job_idx_in;
   logic [JOB_W-1:0]   job_last_ff, job_last_in;
   logic [TIME_W-1:0]  cur_t_ff, cur_t_in;
   logic               prev_ff, prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic [OBS_W-1:0]   rsp_obs_ff;
   logic signed [DATA_W-1:0] rsp_force_ff;
   logic               rsp_last_ff;

   logic               req_acc, kern_we, drift_we, hist_we, complete, fin;
   logic [JOB_W:0]     njobs;
   logic               out_free, eng_take, eng_start, eng_busy;
   job_type            job;
   eng_res_type        eng_res;

   logic [HIST_AW-1:0]  hist_waddr, hist_raddr;
   logic [DRIFT_AW-1:0] drift_waddr, drift_raddr;
   logic [KERN_AW-1:0]  kern_waddr, kern_raddr;
   logic [DATA_W-1:0]   hist_rdata, drift_rdata, kern_rdata;

   assign req_stall = (ctl_state_ff != CTL_IDLE);
   assign req_acc   = req_valid && !req_stall;

   assign kern_we  = req_acc && req_mode == MODE_KERNEL && int'(req_time_a) < TSTEPS
                     && int'(req_time_b) < TSTEPS && int'(req_row_obs) < NOBS
                     && int'(req_col_obs) < NOBS;
   assign drift_we = req_acc && req_mode == MODE_DRIFT && int'(req_time_a) < TSTEPS
                     && int'(req_row_obs) < NOBS && int'(req_col_obs) < NOBS;
   assign hist_we  = req_acc && req_mode == MODE_SAMPLE && req_time_a == step_ff
                     && int'(req_col_obs) < NOBS;
   assign complete = hist_we && (int'(obs_cnt_ff) + 1 == NOBS);
   assign fin      = req_final_step || int'(req_time_a) == TSTEPS - 1;
   assign njobs    = (JOB_W+1)'(((req_time_a != '0) ? NOBS : 0) + (fin ? NOBS : 0));

   assign kern_waddr  = KERN_AW'(((int'(req_time_a) * TSTEPS + int'(req_time_b)) * NOBS
                                  + int'(req_row_obs)) * NOBS + int'(req_col_obs));
   assign drift_waddr = DRIFT_AW'((int'(req_time_a) * NOBS + int'(req_row_obs)) * NOBS
                                  + int'(req_col_obs));
   assign hist_waddr  = HIST_AW'(int'(req_time_a) * NOBS + int'(req_col_obs));

   always_comb begin
      if (prev_ff && int'(job_idx_ff) < NOBS) begin
         job.u      = cur_t_ff - TIME_W'(1);
         job.at_end = 1'b0;
         job.obs    = OBS_W'(job_idx_ff);
      end else begin
         job.u      = cur_t_ff;
         job.at_end = 1'b1;
         job.obs    = prev_ff ? OBS_W'(int'(job_idx_ff) - NOBS) : OBS_W'(job_idx_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eng_take  = (ctl_state_ff == CTL_WAIT) && eng_res.valid && out_free;
   assign eng_start = (ctl_state_ff == CTL_LAUNCH);

   always_comb begin
      ctl_state_in = ctl_state_ff;
      step_in      = step_ff;
      obs_cnt_in   = obs_cnt_ff;
      job_idx_in   = job_idx_ff;
      job_last_in  = job_last_ff;
      cur_t_in     = cur_t_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (ctl_state_ff)
         CTL_IDLE: begin
            if (complete) begin
               obs_cnt_in = '0;
               step_in    = fin ? '0 : (req_time_a + TIME_W'(1));
               if (njobs != '0) begin
                  ctl_state_in = CTL_LAUNCH;
                  job_idx_in   = '0;
                  job_last_in  = JOB_W'(njobs - (JOB_W+1)'(1));
                  cur_t_in     = req_time_a;
                  prev_in      = (req_time_a != '0);
               end
            end else if (hist_we) begin
               obs_cnt_in = obs_cnt_ff + CNT_W'(1);
            end
         end
         CTL_LAUNCH: ctl_state_in = CTL_WAIT;
         CTL_WAIT: begin
            if (eng_take) begin
               rsp_valid_in = 1'b1;
               if (job_idx_ff == job_last_ff) begin
                  ctl_state_in = CTL_IDLE;
               end else begin
                  job_idx_in   = job_idx_ff + JOB_W'(1);
                  ctl_state_in = CTL_LAUNCH;
               end
            end
         end
         default: ctl_state_in = CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff  <= CTL_IDLE;
         step_ff       <= '0;
         obs_cnt_ff    <= '0;
         job_idx_ff    <= '0;
         job_last_ff   <= '0;
         cur_t_ff      <= '0;
         prev_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         inv_step_ff   <= INVERSE_STEP_RST;
         step_third_ff <= STEP_THIRD_RST;
      end else begin
         ctl_state_ff <= ctl_state_in;
         step_ff      <= step_in;
         obs_cnt_ff   <= obs_cnt_in;
         job_idx_ff   <= job_idx_in;
         job_last_ff  <= job_last_in;
         cur_t_ff     <= cur_t_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_INVERSE_STEP: inv_step_ff   <= csr_data;
               CSR_STEP_THIRD:   step_third_ff <= csr_data;
               default:          inv_step_ff   <= inv_step_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eng_take) begin
         rsp_time_ff  <= job.u;
         rsp_obs_ff   <= job.obs;
         rsp_force_ff <= eng_res.force_val;
         rsp_last_ff  <= (job_idx_ff == job_last_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_time  = rsp_time_ff;
   assign rsp_out_obs   = rsp_obs_ff;
   assign rsp_force_res = rsp_force_ff;
   assign rsp_last      = rsp_last_ff;

   lff_ram #(.WIDTH(DATA_W), .DEPTH(KERN_DEPTH)) u_kern_ram (
      .clock   (clock),
      .wr_en   (kern_we),
      .wr_addr (kern_waddr),
      .wr_data (req_value),
      .rd_addr (kern_raddr),
      .rd_data (kern_rdata)
   );

   lff_ram #(.WIDTH(DATA_W), .DEPTH(DRIFT_DEPTH)) u_drift_ram (
      .clock   (clock),
      .wr_en   (drift_we),
      .wr_addr (drift_waddr),
      .wr_data (req_value),
      .rd_addr (drift_raddr),
      .rd_data (drift_rdata)
   );

   lff_ram #(.WIDTH(DATA_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (req_value),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   lff_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (eng_start),
      .job          (job),
      .inverse_step (inv_step_ff),
      .step_third   (step_third_ff),
      .take         (eng_take),
      .res          (eng_res),
      .busy         (eng_busy),
      .hist_raddr   (hist_raddr),
      .drift_raddr  (drift_raddr),
      .kern_raddr   (kern_raddr),
      .hist_rdata   (hist_rdata),
      .drift_rdata  (drift_rdata),
      .kern_rdata   (kern_rdata)
   );

   // engine is only launched when it has gone back to idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      eng_start |-> !eng_busy)
      else $error("engine launched while busy");

   // finishing a step leaves its last force in the output word
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      ($past(ctl_state_ff) == CTL_WAIT && ctl_state_ff == CTL_IDLE) |-> rsp_valid && rsp_last)
      else $error("step finished without last word");

   // no history, kernel or drift write while forces of a step are still being computed
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      eng_busy |-> !hist_we && !kern_we && !drift_we)
      else $error("store written during computation");

endmodule
